// ----- design/acm_pkg.sv -----
// ============================================================================
// acm_pkg: shared types and constants of the argmax confusion matrix counter
// Holds the item kind codes, the controller state type, the command and
// status bundles between controller and datapath, and parameter defaults.
// ============================================================================
`default_nettype none

package acm_pkg;

  // Parameter defaults for the top level.
  localparam int MAX_CLASSES_DEF = 16;
  localparam int COUNT_BITS_DEF  = 32;
  localparam int SCORE_BITS_DEF  = 16;

  // Fixed field widths.
  localparam int KIND_W = 2;
  localparam int IDX_W  = 4;
  localparam int CFG_W  = 5;
  localparam int OUT_W  = 32;

  localparam logic [CFG_W-1:0] CLASS_COUNT_RST = 5'd16;

  // Item kind codes. The fourth code is ignored.
  localparam logic [KIND_W-1:0] KIND_SCORE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CNT_RD,
    ST_CNT_WR
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic score_en;  // Accepted score transaction: update trackers.
    logic read_en;   // Accepted read transaction: read the requested cell.
    logic out_load;  // Load the output register from the read data.
    logic cnt_rd;    // Read the cell of the current pair.
    logic cnt_wr;    // Write back the incremented count and advance the pair.
    logic clr_wr;    // Write zero at the clear counter and advance it.
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic sample_end;  // The incoming score transaction closes its sample.
    logic pair_last;   // The current pair is the last one of the masks.
    logic clr_last;    // The clear counter is at the last cell.
  } sts_t;

endpackage

`default_nettype wire

// ----- design/argmax_confusion_matrix_counter.sv -----
// ============================================================================
// argmax_confusion_matrix_counter: confusion matrix of argmax class pairs
// Tracks the argmax of predicted and reference scores per sample and counts
// every tied (predicted, reference) class pair in a saturating matrix.
// ============================================================================
// Usage. The input channel carries one transaction per score pair, cell read
// or clear; it is taken at a clock edge where in_valid is high and in_stall
// is low. When a score transaction closes a sample, the block then does one
// memory read and one write on the single count memory for each (predicted,
// reference) pair of tied classes. A read transaction does a memory read,
// then loads the output register; its result appears on out_cell_count with
// out_valid. The result waits there while out_stall is high, and score and
// clear transactions are still taken meanwhile, while a further read waits.
// A clear transaction zeroes the counts cell by cell, over all MAX_CLASSES
// squared cells (256 by default). After reset the same clearing sweep runs
// before the first transaction is taken; cfg_wr_en writes class_count at any
// time, its reset value being 16.
// ============================================================================
`default_nettype none

module argmax_confusion_matrix_counter #(
  parameter int MAX_CLASSES = acm_pkg::MAX_CLASSES_DEF,
  parameter int COUNT_BITS  = acm_pkg::COUNT_BITS_DEF,
  parameter int SCORE_BITS  = acm_pkg::SCORE_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Configuration write port for class_count.
  input  wire logic                       cfg_wr_en,
  input  wire logic [acm_pkg::CFG_W-1:0]  cfg_wr_data,
  // Input channel.
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [acm_pkg::KIND_W-1:0] in_kind,
  input  wire logic [SCORE_BITS-1:0]      in_pred_score,
  input  wire logic [SCORE_BITS-1:0]      in_ref_score,
  input  wire logic                       in_last_class,
  input  wire logic [acm_pkg::IDX_W-1:0]  in_read_pred,
  input  wire logic [acm_pkg::IDX_W-1:0]  in_read_ref,
  // Result channel.
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [acm_pkg::OUT_W-1:0]  out_cell_count
);
  import acm_pkg::*;

  // Commands from the controller and status back from the datapath.
  cmd_t cmd;
  sts_t sts;

  // The controller owns both handshakes and the sequencing of memory work.
  acm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath holds the trackers, the count memory and the result.
  acm_dp #(
    .MAX_CLASSES (MAX_CLASSES),
    .COUNT_BITS  (COUNT_BITS),
    .SCORE_BITS  (SCORE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_pred_score  (in_pred_score),
    .in_ref_score   (in_ref_score),
    .in_last_class  (in_last_class),
    .in_read_pred   (in_read_pred),
    .in_read_ref    (in_read_ref),
    .out_cell_count (out_cell_count)
  );

endmodule

`default_nettype wire

// ----- design/acm_track.sv -----
// ============================================================================
// acm_track: running maximum and tie mask of one score stream
// Keeps the best score of the sample so far and a mask of every class that
// equals it. The first class of a sample restarts both.
// ============================================================================
`default_nettype none

module acm_track #(
  parameter int SCORE_BITS  = acm_pkg::SCORE_BITS_DEF,
  parameter int MAX_CLASSES = acm_pkg::MAX_CLASSES_DEF,
  parameter int IW          = $clog2(MAX_CLASSES)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic [SCORE_BITS-1:0]   score,
  input  wire logic [IW-1:0]           pos,
  output logic      [MAX_CLASSES-1:0]  mask_r,
  output logic      [MAX_CLASSES-1:0]  mask_nxt
);
  import acm_pkg::*;

  logic signed [SCORE_BITS-1:0] best_r, best_nxt;
  logic        [MAX_CLASSES-1:0] bit_sel;

  always_comb begin
    bit_sel  = MAX_CLASSES'(1) << pos;
    best_nxt = best_r;
    mask_nxt = mask_r;
    if (en) begin
      if (pos == '0 || $signed(score) > best_r) begin
        best_nxt = $signed(score);
        mask_nxt = bit_sel;
      end else if ($signed(score) == best_r) begin
        mask_nxt = mask_r | bit_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
      mask_r <= '0;
    end else begin
      best_r <= best_nxt;
      mask_r <= mask_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/acm_dp.sv -----
// ============================================================================
// acm_dp: datapath of the argmax confusion matrix counter
// Class position and class count registers, the two argmax trackers, the
// pair walker over the tie masks, the count memory and the output register.
// ============================================================================
`default_nettype none

module acm_dp #(
  parameter int MAX_CLASSES = acm_pkg::MAX_CLASSES_DEF,
  parameter int COUNT_BITS  = acm_pkg::COUNT_BITS_DEF,
  parameter int SCORE_BITS  = acm_pkg::SCORE_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire acm_pkg::cmd_t              cmd,
  output acm_pkg::sts_t                   sts,
  input  wire logic                       cfg_wr_en,
  input  wire logic [acm_pkg::CFG_W-1:0]  cfg_wr_data,
  input  wire logic [SCORE_BITS-1:0]      in_pred_score,
  input  wire logic [SCORE_BITS-1:0]      in_ref_score,
  input  wire logic                       in_last_class,
  input  wire logic [acm_pkg::IDX_W-1:0]  in_read_pred,
  input  wire logic [acm_pkg::IDX_W-1:0]  in_read_ref,
  output logic      [acm_pkg::OUT_W-1:0]  out_cell_count
);
  import acm_pkg::*;

  localparam int IW    = $clog2(MAX_CLASSES);
  localparam int NW    = $clog2(MAX_CLASSES + 1);
  localparam int CW    = (NW > CFG_W) ? NW : CFG_W;
  localparam int CELLS = MAX_CLASSES * MAX_CLASSES;
  localparam int AW    = $clog2(CELLS);
  localparam int AXW   = AW + IDX_W;

  // Class count and position.
  logic [CFG_W-1:0] class_count_r;
  logic [IW-1:0]    pos_r, pos_nxt, pos_eff;
  logic [CW-1:0]    cc_ext, n_w;

  // Status toward the controller.
  logic sample_end, pair_last, clr_last;

  // Trackers.
  logic [MAX_CLASSES-1:0] pred_mask_r, pred_mask_nxt, ref_mask_r, ref_mask_nxt;

  // Pair walker.
  logic [MAX_CLASSES-1:0] pw_r, pw_nxt, rw_r, rw_nxt, p_low, r_low;
  logic [IW-1:0]          p_idx, r_idx;
  logic                   p_one, r_one;

  // Memory and addressing.
  logic [COUNT_BITS-1:0]  mem [CELLS];
  logic [COUNT_BITS-1:0]  rd_data_r, inc_data, wr_data;
  logic [AW-1:0]          pair_addr, read_addr, rd_addr, wr_addr, clr_cnt_r;
  logic [AXW-1:0]         pair_full, read_full;
  logic                   rd_en, wr_en, oor, oor_r;
  logic [COUNT_BITS+OUT_W-1:0] rd_ext;
  logic [OUT_W-1:0]       out_r;

  function automatic logic [IW-1:0] low_idx(input logic [MAX_CLASSES-1:0] m);
    logic [IW-1:0] idx;
    idx = '0;
    for (int i = MAX_CLASSES - 1; i >= 0; i--) begin
      if (m[i]) idx = IW'(i);
    end
    return idx;
  endfunction

  // Members in declaration order of sts_t.
  assign sts = {sample_end, pair_last, clr_last};

  // Effective class count, clamped to 1..MAX_CLASSES.
  always_comb begin
    cc_ext = CW'(class_count_r);
    if (cc_ext == '0) begin
      n_w = CW'(1);
    end else if (cc_ext > CW'(MAX_CLASSES)) begin
      n_w = CW'(MAX_CLASSES);
    end else begin
      n_w = cc_ext;
    end
    if (CW'(pos_r) >= n_w) begin
      pos_eff = IW'(n_w - CW'(1));
    end else begin
      pos_eff = pos_r;
    end
    sample_end = in_last_class || ((CW'(pos_eff) + CW'(1)) >= n_w);
    pos_nxt = pos_r;
    if (cmd.score_en) begin
      pos_nxt = sample_end ? '0 : IW'(pos_eff + IW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_count_r <= CLASS_COUNT_RST;
      pos_r         <= '0;
    end else begin
      if (cfg_wr_en) class_count_r <= cfg_wr_data;
      pos_r <= pos_nxt;
    end
  end

  acm_track #(
    .SCORE_BITS  (SCORE_BITS),
    .MAX_CLASSES (MAX_CLASSES),
    .IW          (IW)
  ) u_pred_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (cmd.score_en),
    .score    (in_pred_score),
    .pos      (pos_eff),
    .mask_r   (pred_mask_r),
    .mask_nxt (pred_mask_nxt)
  );

  acm_track #(
    .SCORE_BITS  (SCORE_BITS),
    .MAX_CLASSES (MAX_CLASSES),
    .IW          (IW)
  ) u_ref_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (cmd.score_en),
    .score    (in_ref_score),
    .pos      (pos_eff),
    .mask_r   (ref_mask_r),
    .mask_nxt (ref_mask_nxt)
  );

  // Pair walker: rows of the predicted mask outer, columns of the
  // reference mask inner, lowest set bit first.
  always_comb begin
    p_low = pw_r & (~pw_r + MAX_CLASSES'(1));
    r_low = rw_r & (~rw_r + MAX_CLASSES'(1));
    p_idx = low_idx(pw_r);
    r_idx = low_idx(rw_r);
    p_one = (pw_r & (pw_r - MAX_CLASSES'(1))) == '0;
    r_one = (rw_r & (rw_r - MAX_CLASSES'(1))) == '0;
    pair_last = p_one && r_one;
    pw_nxt = pw_r;
    rw_nxt = rw_r;
    if (cmd.score_en && sample_end) begin
      pw_nxt = pred_mask_nxt;
      rw_nxt = ref_mask_nxt;
    end else if (cmd.cnt_wr) begin
      if (r_one) begin
        pw_nxt = pw_r & ~p_low;
        rw_nxt = ref_mask_r;
      end else begin
        rw_nxt = rw_r & ~r_low;
      end
    end
  end

  always_ff @(posedge clk) begin
    pw_r <= pw_nxt;
    rw_r <= rw_nxt;
  end

  // Addresses of the current pair and of a requested cell.
  always_comb begin
    pair_full = AXW'(p_idx) * AXW'(MAX_CLASSES) + AXW'(r_idx);
    read_full = AXW'(in_read_pred) * AXW'(MAX_CLASSES) + AXW'(in_read_ref);
    pair_addr = pair_full[AW-1:0];
    read_addr = read_full[AW-1:0];
    oor = (AXW'(in_read_pred) >= AXW'(MAX_CLASSES)) ||
          (AXW'(in_read_ref) >= AXW'(MAX_CLASSES));
    rd_en   = cmd.read_en || cmd.cnt_rd;
    rd_addr = cmd.cnt_rd ? pair_addr : read_addr;
    inc_data = (rd_data_r == '1) ? rd_data_r : rd_data_r + COUNT_BITS'(1);
    wr_en   = cmd.cnt_wr || cmd.clr_wr;
    wr_addr = cmd.clr_wr ? clr_cnt_r : pair_addr;
    wr_data = cmd.clr_wr ? '0 : inc_data;
    clr_last = clr_cnt_r == AW'(CELLS - 1);
    rd_ext = {{OUT_W{1'b0}}, rd_data_r};
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_last ? '0 : clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_en) oor_r <= oor;
    if (cmd.out_load) out_r <= oor_r ? '0 : rd_ext[OUT_W-1:0];
  end

  assign out_cell_count = out_r;

endmodule

`default_nettype wire

// ----- design/acm_ctrl.sv -----
// ============================================================================
// acm_ctrl: controller of the argmax confusion matrix counter
// Sequences the clearing sweep, cell reads and the read-modify-write of
// every tie pair at the end of a sample, and owns both handshakes.
// ============================================================================
`default_nettype none

module acm_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [acm_pkg::KIND_W-1:0]  in_kind,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output acm_pkg::cmd_t                    cmd,
  input  wire acm_pkg::sts_t               sts
);
  import acm_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  always_comb begin
    in_stall = (state_r != ST_IDLE) || (out_valid_r && in_kind == KIND_READ);
    accept   = in_valid && !in_stall;
    cmd          = '0;
    cmd.score_en = accept && in_kind == KIND_SCORE;
    cmd.read_en  = accept && in_kind == KIND_READ;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd.score_en && sts.sample_end) begin
          state_nxt = ST_CNT_RD;
        end else if (cmd.read_en) begin
          state_nxt = ST_READ;
        end else if (accept && in_kind == KIND_CLEAR) begin
          state_nxt = ST_CLEAR;
        end
      end
      ST_READ: begin
        cmd.out_load  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_CNT_RD: begin
        cmd.cnt_rd = 1'b1;
        state_nxt  = ST_CNT_WR;
      end
      ST_CNT_WR: begin
        cmd.cnt_wr = 1'b1;
        state_nxt  = sts.pair_last ? ST_IDLE : ST_CNT_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
